// ===== rtl/mrt_pkg.sv =====
// Shared types and constants for the multi-rate tick timers.
package mrt_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 8;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TICKS_PER_SLOW_TICK  = 3'd0,
        CFG_SLOW_TICKS_THREE_SEC = 3'd1,
        CFG_SLOW_TICKS_SAFETY    = 3'd2,
        CFG_SLOW_TICKS_KEY_HOLD  = 3'd3,
        CFG_TICKS_PER_MINUTE     = 3'd4,
        CFG_CHARGE_LIMIT_MINUTES = 3'd5,
        CFG_TICKS_HALF_SECOND    = 3'd6
    } t_cfg_index;

    // Input item, last field in the lowest bit
    typedef struct packed {
        logic [1:0] pad;
        logic       calibration_on;
        logic       charge_timing_on;
        logic       in_discharge_mode;
        logic       key_pressed;
        logic       clear_safety_count;
        logic       safety_timing_on;
    } t_in_item;

    // Result item, last field in the lowest bit
    typedef struct packed {
        logic       pad;
        logic       half_second_tick;
        logic       charge_timeout;
        logic       switch_to_safety;
        logic       key_hold_expired;
        logic       safety_expired;
        logic       three_sec_tick;
        logic       slow_tick;
    } t_out_item;

    localparam logic [7:0] SAFETY_MAX = 8'hFF;

endpackage

// ===== rtl/multi_rate_tick_timers.sv =====
// Top level of the multi-rate tick timers: prescaler and counters in one pass.
//
// An accepted input transaction is loaded into the input register; it moves into the
// result register, which offers the result, when the result stage can take it.
// Throughput: one transaction per cycle while the result stream is not stalled, set
// by the single update of all counter registers in one pass; a stalled result stage
// holds the input stage. Reset (i_rst_n low, synchronous) zeros all counters, empties
// both stages and loads the configuration registers with their default values.
module multi_rate_tick_timers (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mrt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mrt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata from bit 0: safety_timing_on, clear_safety_count, key_pressed,
    // in_discharge_mode, charge_timing_on, calibration_on, two zero bits
    input  logic [mrt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata from bit 0: slow_tick, three_sec_tick, safety_expired,
    // key_hold_expired, switch_to_safety, charge_timeout, half_second_tick, zero
    output logic [mrt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import mrt_pkg::*;

    // Configuration registers
    logic [15:0] r_ticks_per_slow_tick;
    logic [7:0]  r_slow_ticks_three_sec;
    logic [7:0]  r_slow_ticks_safety;
    logic [7:0]  r_slow_ticks_key_hold;
    logic [15:0] r_ticks_per_minute;
    logic [9:0]  r_charge_limit_minutes;
    logic [15:0] r_ticks_half_second;

    // Counter state
    logic [15:0] r_prescale_count,    n_prescale_count;
    logic [7:0]  r_three_sec_count,   n_three_sec_count;
    logic [7:0]  r_safety_count,      n_safety_count;
    logic [7:0]  r_key_hold_count,    n_key_hold_count;
    logic [15:0] r_minute_tick_count, n_minute_tick_count;
    logic [9:0]  r_charge_minute_count, n_charge_minute_count;
    logic [15:0] r_half_second_count, n_half_second_count;

    // Pipeline stages
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item, n_out_item;

    logic advance;   // result stage can take a new item
    logic fire;      // input stage moves into the result stage

    // The user must write configuration only while idle; the block does not enforce this, so always take it
    assign o_cfg_ready = 1'b1;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_slow_tick  <= 16'd100;
            r_slow_ticks_three_sec <= 8'd15;
            r_slow_ticks_safety    <= 8'd50;
            r_slow_ticks_key_hold  <= 8'd100;
            r_ticks_per_minute     <= 16'd30000;
            r_charge_limit_minutes <= 10'd600;
            r_ticks_half_second    <= 16'd250;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TICKS_PER_SLOW_TICK:  r_ticks_per_slow_tick  <= i_cfg_data;
                CFG_SLOW_TICKS_THREE_SEC: r_slow_ticks_three_sec <= i_cfg_data[7:0];
                CFG_SLOW_TICKS_SAFETY:    r_slow_ticks_safety    <= i_cfg_data[7:0];
                CFG_SLOW_TICKS_KEY_HOLD:  r_slow_ticks_key_hold  <= i_cfg_data[7:0];
                CFG_TICKS_PER_MINUTE:     r_ticks_per_minute     <= i_cfg_data;
                CFG_CHARGE_LIMIT_MINUTES: r_charge_limit_minutes <= i_cfg_data[9:0];
                CFG_TICKS_HALF_SECOND:    r_ticks_half_second    <= i_cfg_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // One pass over all counters for the item held in the input register
    always_comb begin
        logic        slow;
        logic [7:0]  safety_base;
        logic [7:0]  key_next;
        logic [9:0]  minute_next;

        n_out_item = '0;

        // Prescaler: increment, wrap at the limit
        n_prescale_count = r_prescale_count + 16'd1;
        slow = (r_ticks_per_slow_tick <= n_prescale_count);
        if (slow) begin
            n_prescale_count = '0;
        end
        n_out_item.slow_tick = slow;

        // Three-second counter
        n_three_sec_count = r_three_sec_count;
        if (slow) begin
            n_three_sec_count = r_three_sec_count + 8'd1;
            if (r_slow_ticks_three_sec <= n_three_sec_count) begin
                n_three_sec_count         = '0;
                n_out_item.three_sec_tick = 1'b1;
            end
        end

        // Safety counter: clear comes first, then saturate at the top
        safety_base    = r_in_item.clear_safety_count ? 8'd0 : r_safety_count;
        n_safety_count = safety_base;
        if (slow && r_in_item.safety_timing_on) begin
            if (safety_base != SAFETY_MAX) begin
                n_safety_count = safety_base + 8'd1;
            end
            n_out_item.safety_expired = (r_slow_ticks_safety <= n_safety_count);
        end

        // Key-hold counter: release seen only on a slow tick
        key_next         = r_key_hold_count + 8'd1;
        n_key_hold_count = r_key_hold_count;
        if (slow) begin
            if (r_in_item.key_pressed) begin
                n_key_hold_count = key_next;
                if (r_slow_ticks_key_hold <= key_next) begin
                    n_key_hold_count            = '0;
                    n_out_item.key_hold_expired = 1'b1;
                    n_out_item.switch_to_safety = r_in_item.in_discharge_mode;
                end
            end else begin
                n_key_hold_count = '0;
            end
        end

        // Charge timer: base ticks into minutes, minutes up to the limit, cleared while off
        minute_next           = r_charge_minute_count + 10'd1;
        n_minute_tick_count   = '0;
        n_charge_minute_count = '0;
        if (r_in_item.charge_timing_on) begin
            n_minute_tick_count   = r_minute_tick_count + 16'd1;
            n_charge_minute_count = r_charge_minute_count;
            if (r_ticks_per_minute <= n_minute_tick_count) begin
                n_minute_tick_count   = '0;
                n_charge_minute_count = minute_next;
                if (r_charge_limit_minutes <= minute_next) begin
                    n_charge_minute_count     = '0;
                    n_out_item.charge_timeout = 1'b1;
                end
            end
        end

        // Calibration counter: hold while off
        n_half_second_count = r_half_second_count;
        if (r_in_item.calibration_on) begin
            n_half_second_count = r_half_second_count + 16'd1;
            if (r_ticks_half_second <= n_half_second_count) begin
                n_half_second_count         = '0;
                n_out_item.half_second_tick = 1'b1;
            end
        end
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_prescale_count      <= '0;
            r_three_sec_count     <= '0;
            r_safety_count        <= '0;
            r_key_hold_count      <= '0;
            r_minute_tick_count   <= '0;
            r_charge_minute_count <= '0;
            r_half_second_count   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            // Advance the counters only when the item leaves the input stage
            if (fire) begin
                r_prescale_count      <= n_prescale_count;
                r_three_sec_count     <= n_three_sec_count;
                r_safety_count        <= n_safety_count;
                r_key_hold_count      <= n_key_hold_count;
                r_minute_tick_count   <= n_minute_tick_count;
                r_charge_minute_count <= n_charge_minute_count;
                r_half_second_count   <= n_half_second_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= t_in_item'(s_axis_tdata);
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

endmodule
